// File: rtl/zcpt_pkg.sv
// Shared types and constants for the zero-cross phase tracker.
`default_nettype none
package zcpt_pkg;
    localparam int SAMPLE_W      = 16;
    localparam int COUNT_W       = 16;
    localparam int STEP_W        = 16;
    localparam int GAIN_W        = 4;
    localparam int ACC_W         = 32;
    localparam int IDX_W         = 10;
    localparam int FRACTION_BITS = 12;
    localparam int TABLE_LAST    = 1023;
    localparam int RMS_START_CNT = 100;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 3;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_HALF  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LOOP_GAIN = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_MIN  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_MAX  = 2'd3;

    localparam logic [COUNT_W-1:0] RST_MIN_HALF  = 16'd100;
    localparam logic [GAIN_W-1:0]  RST_LOOP_GAIN = 4'd3;
    localparam logic [STEP_W-1:0]  RST_STEP_MIN  = 16'd8389;
    localparam logic [STEP_W-1:0]  RST_STEP_MAX  = 16'd13005;

    typedef struct packed {
        logic [COUNT_W-1:0] min_half_count;
        logic [GAIN_W-1:0]  loop_gain;
        logic [STEP_W-1:0]  step_min;
        logic [STEP_W-1:0]  step_max;
    } t_cfg;

    typedef struct packed {
        logic crossing;
        logic polarity;
        logic rms_start;
    } t_hc_info;
endpackage
`default_nettype wire

// File: rtl/zcpt_cfg_regs.sv
// Configuration register file of the zero-cross phase tracker.
`default_nettype none
module zcpt_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [zcpt_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [zcpt_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output zcpt_pkg::t_cfg                      o_cfg
);
    import zcpt_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_half_count <= RST_MIN_HALF;
            r_cfg.loop_gain      <= RST_LOOP_GAIN;
            r_cfg.step_min       <= RST_STEP_MIN;
            r_cfg.step_max       <= RST_STEP_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_MIN_HALF:  r_cfg.min_half_count <= i_cfg_wdata[COUNT_W-1:0];
                REG_LOOP_GAIN: r_cfg.loop_gain      <= i_cfg_wdata[GAIN_W-1:0];
                REG_STEP_MIN:  r_cfg.step_min       <= i_cfg_wdata[STEP_W-1:0];
                REG_STEP_MAX:  r_cfg.step_max       <= i_cfg_wdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule
`default_nettype wire

// File: rtl/zcpt_half_cycle.sv
// Polarity tracking, half-cycle counters and crossing qualification.
`default_nettype none
module zcpt_half_cycle (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_accept,
    input  wire logic [zcpt_pkg::SAMPLE_W-1:0] i_sample,
    input  zcpt_pkg::t_cfg                    i_cfg,
    output zcpt_pkg::t_hc_info                o_info
);
    import zcpt_pkg::*;

    logic               r_polarity;
    logic [COUNT_W-1:0] r_pos_cnt;
    logic [COUNT_W-1:0] r_neg_cnt;
    logic               n_polarity;
    logic [COUNT_W-1:0] n_pos_cnt;
    logic [COUNT_W-1:0] n_neg_cnt;
    logic               s_neg;
    logic               s_pos;
    logic               crossing;
    logic               rms_start;

    function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] c);
        count_up = (&c) ? c : c + 1'b1;
    endfunction

    assign s_neg = i_sample[SAMPLE_W-1];
    assign s_pos = !s_neg && (|i_sample);

    always_comb begin
        n_polarity = r_polarity;
        n_pos_cnt  = r_pos_cnt;
        n_neg_cnt  = r_neg_cnt;
        crossing   = 1'b0;
        rms_start  = 1'b0;
        if (s_pos) begin
            crossing = !r_polarity && (r_neg_cnt > i_cfg.min_half_count);
            if (crossing) begin
                n_polarity = 1'b1;
                n_neg_cnt  = '0;
            end
            n_pos_cnt = count_up(crossing ? '0 : r_pos_cnt);
        end else if (s_neg) begin
            crossing = r_polarity && (r_pos_cnt > i_cfg.min_half_count);
            if (crossing) begin
                n_polarity = 1'b0;
                n_pos_cnt  = '0;
            end
            n_neg_cnt = count_up(crossing ? '0 : r_neg_cnt);
            rms_start = (n_neg_cnt == COUNT_W'(RMS_START_CNT));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_polarity <= 1'b0;
            r_pos_cnt  <= '0;
            r_neg_cnt  <= '0;
        end else if (i_accept) begin
            r_polarity <= n_polarity;
            r_pos_cnt  <= n_pos_cnt;
            r_neg_cnt  <= n_neg_cnt;
        end
    end

    assign o_info.crossing  = crossing;
    assign o_info.polarity  = n_polarity;
    assign o_info.rms_start = rms_start;
endmodule
`default_nettype wire

// File: rtl/zcpt_phase.sv
// Phase step correction, accumulator and sine table index.
`default_nettype none
module zcpt_phase (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_accept,
    input  wire logic                      i_crossing,
    input  zcpt_pkg::t_cfg                 i_cfg,
    output logic [zcpt_pkg::IDX_W-1:0]     o_phase_index,
    output logic [zcpt_pkg::STEP_W-1:0]    o_phase_step
);
    import zcpt_pkg::*;

    localparam int RAW_W = ACC_W - FRACTION_BITS;
    localparam int SUM_W = RAW_W + GAIN_W + 3;

    logic [STEP_W-1:0]        r_step;
    logic [ACC_W-1:0]         r_acc;
    logic [STEP_W-1:0]        n_step;
    logic [ACC_W-1:0]         n_acc;
    logic [RAW_W-1:0]         raw;
    logic signed [SUM_W-1:0]  err;
    logic signed [SUM_W-1:0]  prod;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  lim_max;
    logic signed [SUM_W-1:0]  lim_min;
    logic [STEP_W-1:0]        clamped;
    logic [ACC_W-1:0]         acc_base;
    logic [RAW_W-1:0]         idx_raw;
    logic [RAW_W-1:0]         idx_fold;
    logic [RAW_W-1:0]         idx_sat;

    // index error against the end of the table, from the index before the clear
    assign raw     = r_acc[ACC_W-1:FRACTION_BITS];
    assign err     = $signed(SUM_W'(TABLE_LAST)) - $signed({{(SUM_W-RAW_W){1'b0}}, raw});
    assign prod    = err * $signed({{(SUM_W-GAIN_W){1'b0}}, i_cfg.loop_gain});
    assign sum     = prod + $signed({{(SUM_W-STEP_W){1'b0}}, r_step});
    assign lim_max = $signed({{(SUM_W-STEP_W){1'b0}}, i_cfg.step_max});
    assign lim_min = $signed({{(SUM_W-STEP_W){1'b0}}, i_cfg.step_min});

    // max wins first; min only applies when not above max
    always_comb begin
        if (sum > lim_max) begin
            clamped = i_cfg.step_max;
        end else if (sum < lim_min) begin
            clamped = i_cfg.step_min;
        end else begin
            clamped = sum[STEP_W-1:0];
        end
    end

    assign n_step   = i_crossing ? clamped : r_step;
    assign acc_base = i_crossing ? '0 : r_acc;
    assign n_acc    = acc_base + {{(ACC_W-STEP_W){1'b0}}, n_step};

    // fold once past the table end, then saturate
    assign idx_raw  = n_acc[ACC_W-1:FRACTION_BITS];
    assign idx_fold = (idx_raw > RAW_W'(TABLE_LAST)) ? idx_raw - RAW_W'(TABLE_LAST) : idx_raw;
    assign idx_sat  = (idx_fold > RAW_W'(TABLE_LAST)) ? RAW_W'(TABLE_LAST) : idx_fold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_acc  <= '0;
        end else if (i_accept) begin
            r_step <= n_step;
            r_acc  <= n_acc;
        end
    end

    assign o_phase_index = idx_sat[IDX_W-1:0];
    assign o_phase_step  = n_step;
endmodule
`default_nettype wire

// File: rtl/zero_cross_phase_tracker.sv
// Zero-cross phase tracker: one grid phase result per line-voltage sample.
//
// Input stream (s): one signed 16-bit line-voltage sample per transfer.
// Output stream (m): one result per accepted sample, in order. tdata holds
//   the sine table index and the current phase step; tuser holds polarity,
//   the qualified-crossing flag and the RMS start pulse.
// Config port: write enable, 2-bit register index, 16-bit data; written in
//   the cycle the enable is high. Change registers only while the block is
//   idle.
// Result: registered, valid in the cycle after the sample transfers.
// Throughput: one sample per cycle unless stalled; the update (step correction,
//   clamp, accumulator add, table fold) runs between input and result register.
// Stall: while the result register is full and m tready is low, s tready is
//   low; it rises again in the cycle the result is taken, so a new sample can
//   transfer in the same cycle the previous result leaves.
// Reset: synchronous, active low. Clears the result valid flag, polarity,
//   counters, step and accumulator, and restores register defaults.
`default_nettype none
module zero_cross_phase_tracker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // [15:0] line_voltage
    input  wire logic [zcpt_pkg::S_TDATA_W-1:0] i_s_tdata,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // [9:0] phase_index, [25:10] phase_step, [31:26] zero
    output logic [zcpt_pkg::M_TDATA_W-1:0]      o_m_tdata,
    // [0] polarity, [1] crossing, [2] rms_start
    output logic [zcpt_pkg::M_TUSER_W-1:0]      o_m_tuser,
    input  wire logic                           i_cfg_we,
    input  wire logic [zcpt_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [zcpt_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import zcpt_pkg::*;

    t_cfg              cfg;
    t_hc_info          hc_info;
    logic              accept;
    logic [IDX_W-1:0]  phase_index;
    logic [STEP_W-1:0] phase_step;

    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    logic [M_TUSER_W-1:0] r_out_user;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    zcpt_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    zcpt_half_cycle u_half (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_sample (i_s_tdata[SAMPLE_W-1:0]),
        .i_cfg    (cfg),
        .o_info   (hc_info)
    );

    zcpt_phase u_phase (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_crossing    (hc_info.crossing),
        .i_cfg         (cfg),
        .o_phase_index (phase_index),
        .o_phase_step  (phase_step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {{(M_TDATA_W-STEP_W-IDX_W){1'b0}}, phase_step, phase_index};
            r_out_user <= {hc_info.rms_start, hc_info.crossing, hc_info.polarity};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    // a crossing starts a fresh half cycle, so the RMS pulse cannot coincide
    a_cross_no_rms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> !o_m_tuser[2])
        else $error("crossing and rms_start in the same result");

    // after a crossing the step is within its clamp
    a_cross_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |->
        ((o_m_tdata[IDX_W+STEP_W-1:IDX_W] <= cfg.step_max) ||
         (o_m_tdata[IDX_W+STEP_W-1:IDX_W] == cfg.step_min)))
        else $error("phase step outside clamp after crossing");

    // output register empties on reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // a new result only follows an accepted sample
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(accept) && $past(o_m_tvalid && i_m_tready)) |-> !o_m_tvalid)
        else $error("result valid without a sample");
endmodule
`default_nettype wire
